// ----- rtl/hkt_pkg.sv -----
// ----------------------------------------------------------------------------
// hkt_pkg
// Shared types, field widths and codes for the held key table.
// ----------------------------------------------------------------------------
`default_nettype none

package hkt_pkg;

  localparam int SLOTS_DEF = 64;

  localparam int REQ_W    = 1;
  localparam int KPART_W  = 4;
  localparam int KEY_W    = 2 * KPART_W;
  localparam int FRAME_W  = 8;
  localparam int HOLD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;
  localparam int ENTRY_W  = KEY_W + FRAME_W + HOLD_W;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_UPDATE = 1'b0;
  localparam logic [REQ_W-1:0] REQ_SWEEP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_UPDATED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SWEPT    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } hkt_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } hkt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } hkt_stat_t;

endpackage

`default_nettype wire

// ----- rtl/hkt_ram.sv -----
// ----------------------------------------------------------------------------
// hkt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hkt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkt_ctrl
// Sequencer: idle, scan over all slots, finish and report.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output hkt_pkg::hkt_cmd_t       cmd,
  input  wire hkt_pkg::hkt_stat_t stat
);

  import hkt_pkg::*;

  hkt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/hkt_dp.sv -----
// ----------------------------------------------------------------------------
// hkt_dp
// Datapath: slot memory, valid bits, scan pipeline and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hkt_dp #(
  parameter int SLOTS = hkt_pkg::SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire hkt_pkg::hkt_cmd_t               cmd,
  output hkt_pkg::hkt_stat_t                   stat,
  input  wire logic [hkt_pkg::REQ_W-1:0]       in_req_type,
  input  wire logic [hkt_pkg::KPART_W-1:0]     in_key_row,
  input  wire logic [hkt_pkg::KPART_W-1:0]     in_key_column,
  input  wire logic [hkt_pkg::FRAME_W-1:0]     in_frame_tag,
  output logic                                 out_strobe,
  output logic      [hkt_pkg::STATUS_W-1:0]    out_status,
  output logic      [hkt_pkg::HOLD_W-1:0]      out_hold_count,
  output logic      [hkt_pkg::TOTAL_W-1:0]     out_held_keys,
  output logic      [hkt_pkg::TOTAL_W-1:0]     out_released_keys
);

  import hkt_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS);

  // request latch
  logic [REQ_W-1:0]   req_r,   req_nxt;
  logic [KEY_W-1:0]   key_r,   key_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  // scan pipeline
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             issue;

  // search results and totals
  logic              match_r, match_nxt;
  logic [IDX_W-1:0]  match_idx_r, match_idx_nxt;
  logic [HOLD_W-1:0] match_hold_r, match_hold_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  rel_r, rel_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;

  // result registers
  logic                out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [HOLD_W-1:0]   hold_out_r, hold_out_nxt;
  logic [TOTAL_W-1:0]  held_out_r, held_out_nxt;
  logic [TOTAL_W-1:0]  rel_out_r, rel_out_nxt;

  // memory ports
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [FRAME_W-1:0] rd_frame;
  logic [HOLD_W-1:0]  rd_hold;
  logic [HOLD_W-1:0]  hold_inc;
  logic               chk_live;

  hkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rd_key   = rdata[ENTRY_W-1 -: KEY_W];
  assign rd_frame = rdata[HOLD_W +: FRAME_W];
  assign rd_hold  = rdata[HOLD_W-1:0];
  assign hold_inc = (rd_hold == HOLD_MAX) ? rd_hold : rd_hold + HOLD_W'(1);
  assign chk_live = chk_vld_r && valid_r[chk_idx_r];

  assign issue          = cmd.scan && (idx_r != LAST_CNT);
  assign stat.scan_done = cmd.scan && (idx_r == LAST_CNT) && !chk_vld_r;

  always_comb begin
    req_nxt        = req_r;
    key_nxt        = key_r;
    frame_nxt      = frame_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = issue;
    chk_idx_nxt    = idx_r[IDX_W-1:0];
    match_nxt      = match_r;
    match_idx_nxt  = match_idx_r;
    match_hold_nxt = match_hold_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    held_nxt       = held_r;
    rel_nxt        = rel_r;
    valid_nxt      = valid_r;
    we             = 1'b0;
    waddr          = chk_idx_r;
    wdata          = {key_r, frame_r, hold_inc};

    if (cmd.load) begin
      req_nxt   = in_req_type;
      key_nxt   = {in_key_row, in_key_column};
      frame_nxt = in_frame_tag;
      idx_nxt   = '0;
      match_nxt = 1'b0;
      free_nxt  = 1'b0;
      held_nxt  = '0;
      rel_nxt   = '0;
    end

    if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end

    // evaluate the slot read in the previous cycle
    if (chk_vld_r) begin
      if (req_r == REQ_SWEEP) begin
        if (chk_live) begin
          if (rd_frame != frame_r) begin
            valid_nxt[chk_idx_r] = 1'b0;
            rel_nxt              = rel_r + CNT_W'(1);
          end else begin
            we       = 1'b1;
            wdata    = {rd_key, rd_frame, hold_inc};
            held_nxt = held_r + CNT_W'(1);
          end
        end
      end else begin
        if (chk_live && (rd_key == key_r)) begin
          match_nxt      = 1'b1;
          match_idx_nxt  = chk_idx_r;
          match_hold_nxt = rd_hold;
        end
        if (!valid_r[chk_idx_r]) begin
          // ascending scan: the last free slot seen is the highest one
          free_nxt     = 1'b1;
          free_idx_nxt = chk_idx_r;
        end
      end
    end

    // commit the update or insert
    if (cmd.finish && (req_r == REQ_UPDATE)) begin
      if (match_r) begin
        we    = 1'b1;
        waddr = match_idx_r;
        wdata = {key_r, frame_r, match_hold_r};
      end else if (free_r) begin
        we                    = 1'b1;
        waddr                 = free_idx_r;
        wdata                 = {key_r, frame_r, {HOLD_W{1'b0}}};
        valid_nxt[free_idx_r] = 1'b1;
      end
    end
  end

  always_comb begin
    out_strobe_nxt = cmd.finish;
    status_nxt     = status_r;
    hold_out_nxt   = hold_out_r;
    held_out_nxt   = held_out_r;
    rel_out_nxt    = rel_out_r;
    if (cmd.finish) begin
      hold_out_nxt = '0;
      held_out_nxt = '0;
      rel_out_nxt  = '0;
      if (req_r == REQ_SWEEP) begin
        status_nxt   = STAT_SWEPT;
        held_out_nxt = TOTAL_W'(held_r);
        rel_out_nxt  = TOTAL_W'(rel_r);
      end else if (match_r) begin
        status_nxt   = STAT_UPDATED;
        hold_out_nxt = match_hold_r;
      end else if (free_r) begin
        status_nxt = STAT_INSERTED;
      end else begin
        status_nxt = STAT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    frame_r      <= frame_nxt;
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    match_r      <= match_nxt;
    match_idx_r  <= match_idx_nxt;
    match_hold_r <= match_hold_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    held_r       <= held_nxt;
    rel_r        <= rel_nxt;
    status_r     <= status_nxt;
    hold_out_r   <= hold_out_nxt;
    held_out_r   <= held_out_nxt;
    rel_out_r    <= rel_out_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = status_r;
  assign out_hold_count    = hold_out_r;
  assign out_held_keys     = held_out_r;
  assign out_released_keys = rel_out_r;

endmodule

`default_nettype wire

// ----- rtl/held_key_table.sv -----
// ----------------------------------------------------------------------------
// held_key_table
// Fixed table of held keyboard keys: update/insert by matrix position and
// sweep by current scan frame, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+-------------------
//  request  | in_req_type, in_key_row, in_key_column,      | start && !busy
//           | in_frame_tag                                 |
//  result   | out_status, out_hold_count, out_held_keys,   | out_strobe, one
//           | out_released_keys                            | cycle, no stall
//
//  Timing: a request runs through a scan that reads the slot memory one
//  entry per cycle, then through the finish state, with busy high in both.
//  busy falls in the cycle the result shows, so the next transaction may
//  start there.
//  Reset: synchronous, active low; empties the table (valid bits cleared at
//  once, no clearing pass) and drops any transaction in flight.
//  Stalls: the receiver cannot hold results off; the sender is held by busy.
// ----------------------------------------------------------------------------
`default_nettype none

module held_key_table #(
  parameter int SLOTS = hkt_pkg::SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [hkt_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [hkt_pkg::KPART_W-1:0]  in_key_row,
  input  wire logic [hkt_pkg::KPART_W-1:0]  in_key_column,
  input  wire logic [hkt_pkg::FRAME_W-1:0]  in_frame_tag,
  output logic                              out_strobe,
  output logic      [hkt_pkg::STATUS_W-1:0] out_status,
  output logic      [hkt_pkg::HOLD_W-1:0]   out_hold_count,
  output logic      [hkt_pkg::TOTAL_W-1:0]  out_held_keys,
  output logic      [hkt_pkg::TOTAL_W-1:0]  out_released_keys
);

  import hkt_pkg::*;

  // Controller and datapath talk only through these two bundles.
  hkt_cmd_t  cmd;
  hkt_stat_t stat;

  // Sequence each transaction: accept, scan every slot, then commit and
  // register the report in the finish cycle.
  hkt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Hold the slot memory and valid bits; search for the key and the
  // highest free slot during an update scan, free or age entries during a
  // sweep scan, and register the result.
  hkt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_key_row        (in_key_row),
    .in_key_column     (in_key_column),
    .in_frame_tag      (in_frame_tag),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_hold_count    (out_hold_count),
    .out_held_keys     (out_held_keys),
    .out_released_keys (out_released_keys)
  );

endmodule

`default_nettype wire

// ----- rtl/held_key_table_checker.sv -----
// ----------------------------------------------------------------------------
// held_key_table_checker
// Port-level checks on the held key table, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module held_key_table_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_strobe,
  input wire logic [hkt_pkg::STATUS_W-1:0] out_status,
  input wire logic [hkt_pkg::HOLD_W-1:0]   out_hold_count,
  input wire logic [hkt_pkg::TOTAL_W-1:0]  out_held_keys,
  input wire logic [hkt_pkg::TOTAL_W-1:0]  out_released_keys
);

  import hkt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result without a transaction in flight");

  a_sweep_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == STAT_SWEPT)) |-> (out_hold_count == '0))
    else $error("sweep result carries a hold count");

  a_update_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != STAT_SWEPT)) |->
      ((out_held_keys == '0) && (out_released_keys == '0)))
    else $error("update result carries sweep totals");

endmodule

bind held_key_table held_key_table_checker u_held_key_table_checker (.*);

`default_nettype wire
